// ----- sv/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, fixed-point constants and saturating Q8.24 helpers for the
// plug flow friction RK3 update unit.
// ----------------------------------------------------------------------------
package pfr_pkg;

	localparam int CFG_W     = 25;
	localparam int IDX_W     = 3;
	localparam int DIV_STEPS = 32;
	localparam int Q_ROUNDS  = 3;
	localparam int N_ROUNDS  = 2 * Q_ROUNDS;
	localparam int ROUND_W   = 3;

	localparam logic signed [31:0] FX_ONE = 32'sd16777216;
	localparam logic signed [31:0] FX_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] FX_MIN = 32'sh80000000;
	localparam logic signed [31:0] C_3_4  = 32'sd12582912;
	localparam logic signed [31:0] C_1_4  = 32'sd4194304;
	localparam logic signed [31:0] C_1_3  = 32'sd5592405;
	localparam logic signed [31:0] C_2_3  = 32'sd11184811;

	localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
	localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

	localparam logic [CFG_W-1:0] RST_YIELD = 25'd5033165;
	localparam logic [CFG_W-1:0] RST_IBETA = 25'd621378;
	localparam logic [CFG_W-1:0] RST_DT    = 25'd16777;
	localparam logic [CFG_W-1:0] RST_DRY   = 25'd16777;
	localparam logic [CFG_W-1:0] RST_SLOW  = 25'd4110;

	typedef enum logic [IDX_W-1:0] {
		CFG_YIELD = 3'd0,
		CFG_IBETA = 3'd1,
		CFG_DT    = 3'd2,
		CFG_DRY   = 3'd3,
		CFG_SLOW  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] yield_coef;
		logic [CFG_W-1:0] inv_beta;
		logic [CFG_W-1:0] dt;
		logic [CFG_W-1:0] dry_thr;
		logic [CFG_W-1:0] slow_thr;
	} cfg_t;

	// Per-item context carried down the whole pipeline.
	typedef struct packed {
		logic signed [31:0] h;
		logic signed [31:0] q;
		logic signed [31:0] up;
		logic signed [31:0] m;
		logic signed [31:0] qn;
		logic signed [31:0] t0;
		logic signed [31:0] t1;
		logic               gate;
		logic               wet;
		logic               sat;
		logic               sat_t;
	} ctx_t;

	typedef struct packed {
		logic signed [31:0] v;
		logic               s;
	} res_t;

	function automatic res_t fx_clamp(input logic signed [63:0] x);
		res_t r;
		r.s = (x > WIDE_MAX) || (x < WIDE_MIN);
		if (x > WIDE_MAX) begin
			r.v = FX_MAX;
		end else if (x < WIDE_MIN) begin
			r.v = FX_MIN;
		end else begin
			r.v = x[31:0];
		end
		return r;
	endfunction

	function automatic res_t fx_add(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		return fx_clamp(64'(s));
	endfunction

	function automatic res_t fx_sub(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) - 33'(b);
		return fx_clamp(64'(s));
	endfunction

	function automatic res_t fx_tri(input logic signed [31:0] a);
		logic signed [33:0] s;
		s = 34'(a) + 34'(a) + 34'(a);
		return fx_clamp(64'(s));
	endfunction

	// Product back to Q8.24: floor by arithmetic shift, then clamp.
	function automatic res_t fx_fix(input logic signed [63:0] p);
		return fx_clamp(p >>> 24);
	endfunction

	function automatic logic signed [31:0] fx_yt(input logic signed [31:0] v,
		input logic [CFG_W-1:0] yc);
		logic signed [31:0] a;
		a = $signed({7'd0, yc});
		if (v > 32'sd0) begin
			return a;
		end else if (v < 32'sd0) begin
			return -a;
		end else begin
			return 32'sd0;
		end
	endfunction

	function automatic logic [1:0] rk_pos(input logic [ROUND_W-1:0] idx);
		if (idx >= ROUND_W'(Q_ROUNDS)) begin
			return 2'(idx - ROUND_W'(Q_ROUNDS));
		end else begin
			return 2'(idx);
		end
	endfunction

	function automatic logic signed [31:0] rk_ca(input logic [ROUND_W-1:0] idx);
		case (rk_pos(idx))
			2'd0:    return 32'sd0;
			2'd1:    return C_3_4;
			default: return C_1_3;
		endcase
	endfunction

	function automatic logic signed [31:0] rk_cb(input logic [ROUND_W-1:0] idx);
		case (rk_pos(idx))
			2'd0:    return FX_ONE;
			2'd1:    return C_1_4;
			default: return C_2_3;
		endcase
	endfunction

endpackage

// ----- sv/pfr_div.sv -----
// ----------------------------------------------------------------------------
// pfr_div
// Pipelined saturating Q8.24 divider, one quotient bit per stage, with the
// item context carried alongside.
// ----------------------------------------------------------------------------
module pfr_div import pfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	input  ctx_t               ctx_in,
	output logic               out_vld,
	output res_t               quo,
	output ctx_t               ctx_out
);

	typedef struct packed {
		ctx_t        ctx;
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] dmag;
		logic [7:0]  low;
		logic        neg;
		logic        a_pos;
		logic        a_neg;
		logic        bz;
		logic        ovf;
	} dst_t;

	function automatic dst_t div_step(input dst_t d);
		dst_t        r;
		logic [32:0] rt;
		logic        ge;
		r  = d;
		rt = {d.rem, d.low[7]};
		ge = rt >= {1'b0, d.dmag};
		r.rem = ge ? 32'(rt - {1'b0, d.dmag}) : rt[31:0];
		r.quo = {d.quo[30:0], ge};
		r.low = {d.low[6:0], 1'b0};
		return r;
	endfunction

	dst_t        first_d;
	logic [31:0] amag;
	logic [31:0] bmag;
	dst_t        div_s [0:DIV_STEPS];
	logic        vld_s [0:DIV_STEPS];
	res_t        fin;
	res_t        res_s;
	ctx_t        ctx_s;
	logic        vld_o;

	always_comb begin
		amag = num[31] ? (~num + 1'b1) : num;
		bmag = den[31] ? (~den + 1'b1) : den;
		first_d.ctx   = ctx_in;
		first_d.rem   = {8'd0, amag[31:8]};
		first_d.quo   = '0;
		first_d.dmag  = bmag;
		first_d.low   = amag[7:0];
		first_d.neg   = num[31] ^ den[31];
		first_d.a_pos = num > 32'sd0;
		first_d.a_neg = num[31];
		first_d.bz    = den == 32'sd0;
		// quotient of 2^32 or more cannot be reached by the bit steps
		first_d.ovf   = {8'd0, amag} >= {bmag, 8'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) vld_s[k] <= 1'b0;
			vld_o <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 0; k < DIV_STEPS; k++) vld_s[k+1] <= vld_s[k];
			vld_o <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= first_d;
			for (int k = 0; k < DIV_STEPS; k++) div_s[k+1] <= div_step(div_s[k]);
			res_s <= fin;
			ctx_s <= div_s[DIV_STEPS].ctx;
		end
	end

	always_comb begin
		fin.s = 1'b0;
		fin.v = 32'sd0;
		if (div_s[DIV_STEPS].bz) begin
			fin.s = 1'b1;
			if (div_s[DIV_STEPS].a_pos) fin.v = FX_MAX;
			else if (div_s[DIV_STEPS].a_neg) fin.v = FX_MIN;
		end else if (div_s[DIV_STEPS].ovf) begin
			fin.s = 1'b1;
			fin.v = div_s[DIV_STEPS].neg ? FX_MIN : FX_MAX;
		end else if (!div_s[DIV_STEPS].neg) begin
			fin.s = div_s[DIV_STEPS].quo[31];
			fin.v = fin.s ? FX_MAX : $signed(div_s[DIV_STEPS].quo);
		end else begin
			fin.s = div_s[DIV_STEPS].quo > 32'h80000000;
			fin.v = fin.s ? FX_MIN : $signed(32'd0 - div_s[DIV_STEPS].quo);
		end
	end

	assign out_vld = vld_o;
	assign quo     = res_s;
	assign ctx_out = ctx_s;

endmodule

// ----- sv/pfr_round.sv -----
// ----------------------------------------------------------------------------
// pfr_round
// One RK3 sub-stage of either friction rule: two pipelined divisions, the
// rule's fixed-point arithmetic and the weighted stage update.
// ----------------------------------------------------------------------------
module pfr_round import pfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [ROUND_W-1:0] idx,
	input  cfg_t               cfg,
	input  logic               in_vld,
	input  ctx_t               ctx_in,
	output logic               out_vld,
	output ctx_t               ctx_out
);

	logic mode;
	logic first;
	logic last_q;

	assign mode   = idx >= ROUND_W'(Q_ROUNDS);
	assign first  = idx == '0;
	assign last_q = idx == ROUND_W'(Q_ROUNDS - 1);

	logic               va;
	res_t               qa;
	ctx_t               ca;
	logic               vb;
	res_t               qb;
	ctx_t               cb;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic               vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	ctx_t               ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	ctx_t               ctx_s6, ctx_s7, ctx_s8, ctx_s9, ctx_s10;
	logic signed [31:0] den_s2;
	logic signed [57:0] prod_s4;
	logic signed [57:0] prod_s6;
	logic signed [63:0] pa_s8, pb_s8, pc_s8;

	res_t               gap, tri3, d2, n2, t1r, inner, f, g, fa, fb, fc, sab, mn;
	logic signed [31:0] yt_m, yt_up;
	ctx_t               ctx_n1, ctx_n2, ctx_n3, ctx_n5, ctx_n7, ctx_n9, ctx_n10;

	// plug-gap quotient: m/up for discharge, qn/m for plug velocity
	pfr_div u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_vld),
		.num    (mode ? ctx_in.qn : ctx_in.m),
		.den    (mode ? ctx_in.m : ctx_in.up),
		.ctx_in (ctx_in),
		.out_vld(va),
		.quo    (qa),
		.ctx_out(ca)
	);

	always_comb begin
		gap  = fx_sub(ca.h, qa.v);
		tri3 = fx_tri(gap.v);
	end

	always_comb begin
		yt_m  = fx_yt(ctx_s1.m, cfg.yield_coef);
		yt_up = fx_yt(ctx_s1.up, cfg.yield_coef);
		if (mode) begin
			d2  = fx_sub(ctx_s1.h, ctx_s1.t0);
			n2  = '{v: yt_m, s: 1'b0};
			t1r = '{v: FX_ONE, s: 1'b0};
		end else begin
			d2  = '{v: ctx_s1.t0, s: 1'b0};
			n2  = fx_add(ctx_s1.up, ctx_s1.up);
			t1r = fx_sub(ctx_s1.h, yt_up);
		end
	end

	pfr_div u_div_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (vld_s2),
		.num    (ctx_s2.t0),
		.den    (den_s2),
		.ctx_in (ctx_s2),
		.out_vld(vb),
		.quo    (qb),
		.ctx_out(cb)
	);

	always_comb begin
		inner = fx_sub(cb.t1, qb.v);
		f     = fx_fix(64'(prod_s4));
		g     = fx_fix(64'(prod_s6));
		fa    = fx_fix(pa_s8);
		fb    = fx_fix(pb_s8);
		fc    = fx_fix(pc_s8);
		sab   = fx_add(fa.v, fb.v);
		mn    = fx_add(ctx_s9.t1, ctx_s9.t0);
	end

	// Next values of the context registers.
	always_comb begin
		// gap and its triple; the first round also settles the wet test
		ctx_n1     = ca;
		ctx_n1.t0  = tri3.v;
		ctx_n1.sat = ca.sat | qa.s | gap.s | tri3.s;
		if (first) begin
			ctx_n1.wet   = ca.gate && (tri3.v < ca.h);
			ctx_n1.sat_t = ca.sat | qa.s | gap.s | tri3.s;
		end

		ctx_n2     = ctx_s1;
		ctx_n2.t0  = n2.v;
		ctx_n2.t1  = t1r.v;
		ctx_n2.sat = ctx_s1.sat | d2.s | n2.s | t1r.s;

		ctx_n3     = cb;
		ctx_n3.t0  = inner.v;
		ctx_n3.sat = cb.sat | qb.s | inner.s;

		ctx_n5     = ctx_s4;
		ctx_n5.t0  = f.v;
		ctx_n5.sat = ctx_s4.sat | f.s;

		ctx_n7     = ctx_s6;
		ctx_n7.t0  = g.v;
		ctx_n7.sat = ctx_s6.sat | g.s;

		ctx_n9     = ctx_s8;
		ctx_n9.t0  = fc.v;
		ctx_n9.t1  = sab.v;
		ctx_n9.sat = ctx_s8.sat | fa.s | fb.s | fc.s | sab.s;

		ctx_n10     = ctx_s9;
		ctx_n10.sat = ctx_s9.sat | mn.s;
		if (last_q) begin
			ctx_n10.qn = mn.v;
			ctx_n10.m  = ctx_s9.up;
		end else begin
			ctx_n10.m  = mn.v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= va;
			vld_s2  <= vld_s1;
			vld_s3  <= vb;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_n1;

			ctx_s2 <= ctx_n2;
			den_s2 <= d2.v;

			ctx_s3 <= ctx_n3;

			ctx_s4  <= ctx_s3;
			prod_s4 <= $signed({1'b0, cfg.inv_beta}) * ctx_s3.t0;

			ctx_s5 <= ctx_n5;

			ctx_s6  <= ctx_s5;
			prod_s6 <= $signed({1'b0, cfg.dt}) * ctx_s5.t0;

			ctx_s7 <= ctx_n7;

			ctx_s8 <= ctx_s7;
			pc_s8  <= rk_cb(idx) * ctx_s7.t0;
			pa_s8  <= rk_ca(idx) * (mode ? ctx_s7.up : ctx_s7.q);
			pb_s8  <= rk_cb(idx) * ctx_s7.m;

			ctx_s9 <= ctx_n9;

			ctx_s10 <= ctx_n10;
		end
	end

	assign out_vld = vld_s10;
	assign ctx_out = ctx_s10;

endmodule

// ----- sv/plug_flow_friction_rk3_update_unit.sv -----
// ----------------------------------------------------------------------------
// plug_flow_friction_rk3_update_unit
// Bingham-type bed friction source term, one SSP-RK3 step per grid cell.
// ----------------------------------------------------------------------------
// Takes one cell (depth, discharge, plug velocity, signed Q8.24) per clock
// while in_ready is high and presents one result per cell in order: the
// input register loads at the transfer, then come six RK sub-stage rounds
// (two bit-per-stage dividers plus ten arithmetic stages each) and one
// output register. Three rounds advance the discharge with friction rule 1,
// the next three advance the plug velocity with rule 2 using the new
// discharge. A cell is wet when depth and plug velocity exceed their
// thresholds and three times (h - q/up) is below h; a dry cell returns zero
// for both values. Every add, product and quotient clamps to 32 bits and,
// for a wet cell, raises saturated; divide by zero also raises it. The
// pipeline moves as a whole and holds only when both the output register and
// its skid slot are full, so in_ready stays high while one finished result
// waits. Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module plug_flow_friction_rk3_update_unit import pfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] depth,
	input  logic signed [31:0] discharge,
	input  logic signed [31:0] plug_velocity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_discharge,
	output logic signed [31:0] new_plug_velocity,
	output logic               wet_cell,
	output logic               saturated
);

	typedef struct packed {
		logic signed [31:0] qn;
		logic signed [31:0] upn;
		logic               wet;
		logic               sat;
	} out_item_t;

	cfg_t      cfg_q;
	logic      en;
	logic      vld_s1;
	ctx_t      ctx_s1;
	logic      rnd_vld [0:N_ROUNDS];
	ctx_t      rnd_ctx [0:N_ROUNDS];
	out_item_t pipe_item;
	out_item_t out_q;
	out_item_t skid_q;
	logic      out_vld_q;
	logic      skid_vld_q;

	// Configuration registers: plain writes, unknown indexes dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yield_coef <= RST_YIELD;
			cfg_q.inv_beta   <= RST_IBETA;
			cfg_q.dt         <= RST_DT;
			cfg_q.dry_thr    <= RST_DRY;
			cfg_q.slow_thr   <= RST_SLOW;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_YIELD: cfg_q.yield_coef <= cfg_data;
				CFG_IBETA: cfg_q.inv_beta   <= cfg_data;
				CFG_DT:    cfg_q.dt         <= cfg_data;
				CFG_DRY:   cfg_q.dry_thr    <= cfg_data;
				CFG_SLOW:  cfg_q.slow_thr   <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Advance everything unless the skid slot already holds a result.
	assign en       = !skid_vld_q;
	assign in_ready = en;

	// Input stage: capture the cell and evaluate the two threshold tests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1.h     <= depth;
			ctx_s1.q     <= discharge;
			ctx_s1.up    <= plug_velocity;
			ctx_s1.m     <= discharge;
			ctx_s1.qn    <= '0;
			ctx_s1.t0    <= '0;
			ctx_s1.t1    <= '0;
			ctx_s1.gate  <= (depth > $signed({7'd0, cfg_q.dry_thr}))
				&& (plug_velocity > $signed({7'd0, cfg_q.slow_thr}));
			ctx_s1.wet   <= 1'b0;
			ctx_s1.sat   <= 1'b0;
			ctx_s1.sat_t <= 1'b0;
		end
	end

	assign rnd_vld[0] = vld_s1;
	assign rnd_ctx[0] = ctx_s1;

	// Three discharge rounds, then three plug velocity rounds.
	for (genvar r = 0; r < N_ROUNDS; r++) begin : g_round
		pfr_round u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.idx    (ROUND_W'(r)),
			.cfg    (cfg_q),
			.in_vld (rnd_vld[r]),
			.ctx_in (rnd_ctx[r]),
			.out_vld(rnd_vld[r+1]),
			.ctx_out(rnd_ctx[r+1])
		);
	end

	// Dry cells return zeros; their flag comes only from the gap test.
	always_comb begin
		pipe_item.wet = rnd_ctx[N_ROUNDS].wet;
		pipe_item.qn  = pipe_item.wet ? rnd_ctx[N_ROUNDS].qn : 32'sd0;
		pipe_item.upn = pipe_item.wet ? rnd_ctx[N_ROUNDS].m : 32'sd0;
		pipe_item.sat = pipe_item.wet ? rnd_ctx[N_ROUNDS].sat
			: (rnd_ctx[N_ROUNDS].gate & rnd_ctx[N_ROUNDS].sat_t);
	end

	// Output register plus one skid slot: a result leaving the pipeline
	// while the output is stalled parks in the skid slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (rnd_vld[N_ROUNDS]) begin
			if (out_vld_q && !out_ready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (rnd_vld[N_ROUNDS]) begin
			if (out_vld_q && !out_ready) begin
				skid_q <= pipe_item;
			end else begin
				out_q <= pipe_item;
			end
		end
	end

	assign out_valid         = out_vld_q;
	assign new_discharge     = out_q.qn;
	assign new_plug_velocity = out_q.upn;
	assign wet_cell          = out_q.wet;
	assign saturated         = out_q.sat;

	a_skid_needs_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid slot full while output register empty");

	a_result_lands : assert property (@(posedge clk) disable iff (!arst_n)
		rnd_vld[N_ROUNDS] && !skid_vld_q |=> out_vld_q)
		else $error("result leaving the pipeline was dropped");

	a_dry_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !wet_cell |-> new_discharge == 32'sd0 && new_plug_velocity == 32'sd0)
		else $error("dry cell returned a nonzero value");

endmodule

// ----- tb/tb_plug_flow_friction_rk3_update_unit.sv -----
// ----------------------------------------------------------------------------
// tb_plug_flow_friction_rk3_update_unit
// Streams grid cells through the friction RK3 unit and checks every result
// against a pinned answer or a Q8.24 bench friction model, under random idling.
// ----------------------------------------------------------------------------
module tb_plug_flow_friction_rk3_update_unit;
	import pfr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELL_COUNT = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 600;
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	logic clk, arst_n;
	logic cfg_write;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [31:0] depth, discharge, plug_velocity;
	logic signed [31:0] new_discharge, new_plug_velocity;
	logic wet_cell, saturated;

	plug_flow_friction_rk3_update_unit DUT (.*);

	// One expected cell answer; the directed table may pin it by hand.
	typedef struct {
		logic signed [31:0] qn;
		logic signed [31:0] upn;
		logic               wet;
		logic               sat;
	} cell_ans_t;

	typedef struct {
		logic signed [31:0] h;
		logic signed [31:0] q;
		logic signed [31:0] up;
		bit                 pinned;
		cell_ans_t          ans;
	} cell_row_t;

	cell_ans_t pending_answers[$];
	cell_row_t cell_table[$];

	// Bench copy of the configuration
	longint m_yield, m_ibeta, m_dt, m_dry, m_slow;
	bit m_sat;

	int mismatches, errors, cells_sent, answers_seen, wet_seen, sat_seen;
	int quiet_cycles;
	bit idle_free, done;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------- friction model ----------------
	function automatic longint clip32(longint v);
		if (v > WMAX) begin
			m_sat = 1;
			return WMAX;
		end
		if (v < WMIN) begin
			m_sat = 1;
			return WMIN;
		end
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b;
		return clip32(p >>> 24);
	endfunction

	function automatic longint qdiv(longint a, longint b);
		if (b == 0) begin
			m_sat = 1;
			return (a > 0) ? WMAX : (a < 0) ? WMIN : 0;
		end
		return clip32((a * 64'sd16777216) / b);
	endfunction

	function automatic longint yield_sign(longint up);
		return (up > 0) ? m_yield : (up < 0) ? -m_yield : 0;
	endfunction

	function automatic longint gap3(longint h, longint q, longint up);
		return clip32(3 * clip32(h - qdiv(q, up)));
	endfunction

	function automatic longint friction_q(longint h, longint q, longint up);
		longint frac, inner;
		frac = qdiv(clip32(up + up), gap3(h, q, up));
		inner = clip32(clip32(h - yield_sign(up)) - frac);
		return qmul(m_ibeta, inner);
	endfunction

	function automatic longint friction_up(longint h, longint q, longint up);
		longint den;
		den = clip32(h - gap3(h, q, up));
		return qmul(m_ibeta, clip32(64'sd16777216 - qdiv(yield_sign(up), den)));
	endfunction

	function automatic cell_ans_t friction_rk3(longint h, longint q, longint up);
		cell_ans_t a;
		longint m, qn, upn;
		bit wet;
		m_sat = 0;
		wet = 0;
		qn = 0;
		upn = 0;
		if (h > m_dry && up > m_slow) wet = gap3(h, q, up) < h;
		if (wet) begin
			m = clip32(q + qmul(m_dt, friction_q(h, q, up)));
			m = clip32(clip32(qmul(C_3_4, q) + qmul(C_1_4, m))
				+ qmul(C_1_4, qmul(m_dt, friction_q(h, m, up))));
			qn = clip32(clip32(qmul(C_1_3, q) + qmul(C_2_3, m))
				+ qmul(C_2_3, qmul(m_dt, friction_q(h, m, up))));
			m = clip32(up + qmul(m_dt, friction_up(h, qn, up)));
			m = clip32(clip32(qmul(C_3_4, up) + qmul(C_1_4, m))
				+ qmul(C_1_4, qmul(m_dt, friction_up(h, qn, m))));
			upn = clip32(clip32(qmul(C_1_3, up) + qmul(C_2_3, m))
				+ qmul(C_2_3, qmul(m_dt, friction_up(h, qn, m))));
		end
		a.qn = qn[31:0];
		a.upn = upn[31:0];
		a.wet = wet;
		a.sat = m_sat;
		return a;
	endfunction

	// ---------------- configuration ----------------
	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_YIELD: m_yield = val;
			CFG_IBETA: m_ibeta = val;
			CFG_DT:    m_dt = val;
			CFG_DRY:   m_dry = val;
			default:   m_slow = val;
		endcase
	endtask

	// Let the pipeline drain fully before touching registers.
	task automatic settle;
		in_valid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ---------------- stimulus ----------------
	task automatic send_cell(cell_row_t r);
		cell_ans_t a;
		while (!idle_free && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		depth <= r.h;
		discharge <= r.q;
		plug_velocity <= r.up;
		a = r.pinned ? r.ans : friction_rk3(r.h, r.q, r.up);
		do @(posedge clk); while (!in_ready);
		pending_answers.push_back(a);
		cells_sent++;
		@(negedge clk);
	endtask

	function automatic cell_row_t row(longint h, longint q, longint up);
		cell_row_t r;
		r.h = h[31:0];
		r.q = q[31:0];
		r.up = up[31:0];
		r.pinned = 0;
		r.ans = '{default: '0};
		return r;
	endfunction

	function automatic cell_row_t dry_row(longint h, longint q, longint up);
		cell_row_t r;
		r = row(h, q, up);
		r.pinned = 1;
		return r;
	endfunction

	// Typical wet cell: h ~ 1, up ~ 1, q a bit below h*up
	function automatic cell_row_t wet_like;
		longint h, up, q;
		h = $urandom_range(32'h0400_0000, 32'h0040_0000);
		up = $urandom_range(32'h0400_0000, 32'h0010_0000);
		q = (h * up) >>> 24;
		q = q - longint'($urandom_range(32'h00FF_FFFF)) * q / 64'sd50000000;
		return row(h, q, up);
	endfunction

	function automatic cell_row_t noise_row;
		return row(longint'($signed($urandom())), longint'($signed($urandom())),
			longint'($signed($urandom())));
	endfunction

	task automatic random_cells(int n);
		for (int i = 0; i < n; i++) send_cell(($urandom_range(99) < 70) ? wet_like() : noise_row());
	endtask

	// ---------------- sink ----------------
	always @(negedge clk) begin
		if (idle_free) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= 25);
	end

	always @(posedge clk) begin
		cell_ans_t e;
		if (arst_n && out_valid && out_ready) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("result with nothing expected at %0t", $time);
			end else begin
				e = pending_answers.pop_front();
				if (wet_cell) wet_seen++;
				if (saturated) sat_seen++;
				if (e.qn !== new_discharge || e.upn !== new_plug_velocity
					|| e.wet !== wet_cell || e.sat !== saturated) begin
					errors++;
					if (mismatches++ < 10)
						$display("cell %0d: exp q=%h up=%h wet=%b sat=%b got q=%h up=%h wet=%b sat=%b",
							answers_seen, e.qn, e.upn, e.wet, e.sat,
							new_discharge, new_plug_velocity, wet_cell, saturated);
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side while work remains.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT && !done) begin
			$display("plug_flow_friction_rk3_update_unit test failed");
			$finish;
		end
	end

	initial begin
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		depth = '0;
		discharge = '0;
		plug_velocity = '0;
		out_ready = 0;
		idle_free = 0;
		done = 0;
		errors = 0;
		mismatches = 0;
		cells_sent = 0;
		answers_seen = 0;
		wet_seen = 0;
		sat_seen = 0;
		quiet_cycles = 0;
		m_yield = RST_YIELD;
		m_ibeta = RST_IBETA;
		m_dt = RST_DT;
		m_dry = RST_DRY;
		m_slow = RST_SLOW;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed rows: dry cells are pinned to zero, the rest go to the model.
		cell_table.push_back(dry_row(0, 0, 0));
		cell_table.push_back(dry_row(WMIN, WMAX, WMAX));
		cell_table.push_back(dry_row(WMAX, WMIN, WMIN));
		cell_table.push_back(dry_row(RST_DRY, 1 << 24, 1 << 24));
		cell_table.push_back(dry_row(1 << 24, 1 << 24, RST_SLOW));
		cell_table.push_back(row(WMAX, WMAX, WMAX));
		cell_table.push_back(row(WMAX, WMIN, 1 << 24));
		cell_table.push_back(row(1 << 24, 1 << 24, 1 << 24));
		cell_table.push_back(row(1 << 24, 32'h00E0_0000, 1 << 24));
		cell_table.push_back(row(1 << 24, 0, 1 << 24));
		cell_table.push_back(row(1 << 24, WMAX, RST_SLOW + 1));
		cell_table.push_back(row(RST_DRY + 1, 1, RST_SLOW + 1));
		cell_table.push_back(row(2 << 24, 3 << 24, 2 << 24));
		cell_table.push_back(row(32'h7000_0000, 32'h7000_0000, 32'h0100_0000));
		cell_table.push_back(row(32'h0300_0000, 32'h0280_0000, 32'h0100_0000));
		cell_table.push_back(row(32'h7FFF_0000, 32'h1000_0000, 32'h7FFF_0000));
		foreach (cell_table[i]) send_cell(cell_table[i]);

		// Hold the sender until everything has come back.
		in_valid <= 1'b0;
		wait (pending_answers.size() == 0);
		random_cells(60);

		// No idling stretch
		idle_free = 1;
		random_cells(60);
		idle_free = 0;

		settle();
		write_reg(CFG_YIELD, '0);
		write_reg(CFG_IBETA, 25'h100_0000);
		write_reg(CFG_DT, 25'h100_0000);
		write_reg(CFG_DRY, '0);
		write_reg(CFG_SLOW, '0);
		random_cells(90);

		settle();
		write_reg(CFG_YIELD, 25'h1FF_FFFF);
		write_reg(CFG_IBETA, 25'h1FF_FFFF);
		write_reg(CFG_DT, 25'h1FF_FFFF);
		write_reg(CFG_DRY, 25'h1FF_FFFF);
		write_reg(CFG_SLOW, 25'h1FF_FFFF);
		random_cells(40);

		settle();
		write_reg(CFG_YIELD, 25'($urandom()));
		write_reg(CFG_IBETA, 25'($urandom_range(25'h100_0000)));
		write_reg(CFG_DT, 25'($urandom_range(25'h010_0000)));
		write_reg(CFG_DRY, 25'($urandom_range(25'h001_0000)));
		write_reg(CFG_SLOW, 25'($urandom_range(25'h001_0000)));
		random_cells(110);

		in_valid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		done = 1;
		$display("%0d cells sent, %0d results (%0d wet, %0d clamped), four register settings",
			cells_sent, answers_seen, wet_seen, sat_seen);
		if (errors == 0 && pending_answers.size() == 0)
			$display("plug_flow_friction_rk3_update_unit test passed");
		else
			$display("plug_flow_friction_rk3_update_unit test failed");
		$finish;
	end
endmodule

// ----- plug_flow_friction_rk3_update_unit.f -----
sv/pfr_pkg.sv
sv/pfr_div.sv
sv/pfr_round.sv
sv/plug_flow_friction_rk3_update_unit.sv
tb/tb_plug_flow_friction_rk3_update_unit.sv
